/* design/lcdnw_pkg.sv */
// Shared types and constants for the character LCD nibble writer.
package lcdnw_pkg;

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_POWER   = 4'd1;
  localparam logic [3:0] PH_EN_HIGH = 4'd2;
  localparam logic [3:0] PH_SETTLE  = 4'd3;
  localparam logic [3:0] PH_EXTRA   = 4'd4;

  // Input beat kinds.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_CURSOR = 3'd3;
  localparam logic [2:0] KIND_INIT   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_PULSE_HIGH   = 3'd0;
  localparam logic [2:0] REG_NIBBLE_SETTLE = 3'd1;
  localparam logic [2:0] REG_DATA_HOLD    = 3'd2;
  localparam logic [2:0] REG_SLOW_COMMAND = 3'd3;
  localparam logic [2:0] REG_POWER_UP     = 3'd4;
  localparam logic [2:0] REG_FUNCTION_SET = 3'd5;
  localparam logic [2:0] REG_DISPLAY_CTRL = 3'd6;
  localparam logic [2:0] REG_ENTRY_MODE   = 3'd7;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Fixed waits of the initialization nibbles.
  localparam logic [15:0] INIT_LONG_US  = 16'd5000;
  localparam logic [15:0] INIT_SHORT_US = 16'd1000;

  // Command bytes and nibbles with a fixed meaning.
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] ROW1_BASE     = 7'h40;
  localparam logic [3:0] NIB_INIT3     = 4'h3;
  localparam logic [3:0] NIB_INIT2     = 4'h2;

  typedef struct packed {
    logic [7:0]  pulse_high_us;
    logic [9:0]  nibble_settle_us;
    logic [9:0]  data_hold_us;
    logic [15:0] slow_command_us;
    logic [15:0] power_up_us;
    logic [7:0]  function_set_word;
    logic [7:0]  display_control_word;
    logic [7:0]  entry_mode_word;
  } cfg_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] pending_byte;
    logic       low_nibble_next;
    logic [3:0] init_step;
    logic       rs;
    logic       en;
    logic [3:0] data;
  } state_t;

  // Result beat, packed so that rs_line sits in bit 0.
  typedef struct packed {
    logic       accepted;
    logic       busy_res;
    logic [3:0] data_lines;
    logic       en_line;
    logic       rs_line;
  } res_t;

endpackage

/* design/char_lcd_nibble_writer.sv */
// Top level of the 4-bit character LCD pin sequencer with a two-beat output buffer.
// A beat's result is registered into the output buffer, behind any results still waiting.
// Throughput: one beat per cycle while the buffer has room; next state is combinational.
// A two-entry output buffer lets input beats keep flowing while one result waits.
// Reset (rst, synchronous): sequencer idle with pins low, timer clear, buffer empty,
// configuration registers back to their default values.
module char_lcd_nibble_writer #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], row[8], col[14:9], zero[15]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // rs_line[0], en_line[1], data_lines[5:2], busy_res[6],
                                 // accepted[7]
  input  logic                                 cfg_we,
  input  logic [lcdnw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lcdnw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lcdnw_pkg::*;

  cfg_t cfg;
  state_t st, st_next;
  logic [TIMER_BITS-1:0] cnt, cnt_next;
  logic step_accepted;
  res_t res_new, q0, q1;
  logic [1:0] count;
  logic push, pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_high_us <= 8'd1;
      cfg.nibble_settle_us <= 10'd100;
      cfg.data_hold_us <= 10'd40;
      cfg.slow_command_us <= 16'd2000;
      cfg.power_up_us <= 16'd50000;
      cfg.function_set_word <= 8'd40;
      cfg.display_control_word <= 8'd12;
      cfg.entry_mode_word <= 8'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_HIGH:    cfg.pulse_high_us <= cfg_data[7:0];
        REG_NIBBLE_SETTLE: cfg.nibble_settle_us <= cfg_data[9:0];
        REG_DATA_HOLD:     cfg.data_hold_us <= cfg_data[9:0];
        REG_SLOW_COMMAND:  cfg.slow_command_us <= cfg_data[15:0];
        REG_POWER_UP:      cfg.power_up_us <= cfg_data[15:0];
        REG_FUNCTION_SET:  cfg.function_set_word <= cfg_data[7:0];
        REG_DISPLAY_CTRL:  cfg.display_control_word <= cfg_data[7:0];
        REG_ENTRY_MODE:    cfg.entry_mode_word <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lcdnw_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .cfg        (cfg),
    .st         (st),
    .cnt        (cnt),
    .kind       (s_tuser),
    .byte_value (s_tdata[7:0]),
    .row        (s_tdata[8]),
    .col        (s_tdata[14:9]),
    .st_next    (st_next),
    .cnt_next   (cnt_next),
    .accepted   (step_accepted)
  );

  assign push = s_tvalid && s_tready;
  assign pop = m_tvalid && m_tready;

  // Sequencer state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      cnt <= '0;
    end else if (push) begin
      st <= st_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    res_new.rs_line = st_next.rs;
    res_new.en_line = st_next.en;
    res_new.data_lines = st_next.data;
    res_new.busy_res = (st_next.phase != PH_IDLE);
    res_new.accepted = step_accepted;
  end

  // Two-entry output buffer; q0 is the head.
  assign s_tready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) q0 <= res_new;
        else q1 <= res_new;
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= res_new;
        end else begin
          q0 <= q1;
          q1 <= res_new;
        end
      end
      default: begin
      end
    endcase
  end

  // A request is only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    push && step_accepted |-> st.phase == PH_IDLE)
    else $error("request taken while sequencer busy");

  // The enable strobe is high exactly during the enable phase.
  assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_EN_HIGH) == st.en)
    else $error("enable strobe out of step with phase");

  // A running sequence never rests on an expired timer.
  assert property (@(posedge clk) disable iff (rst)
    st.phase != PH_IDLE |-> cnt != '0)
    else $error("busy with zero wait counter");

endmodule

/* design/lcdnw_step.sv */
// Next-state logic of the sequencer for one input beat.
module lcdnw_step #(
  parameter int TIMER_BITS = 16
) (
  input  lcdnw_pkg::cfg_t        cfg,
  input  lcdnw_pkg::state_t      st,
  input  logic [TIMER_BITS-1:0]  cnt,
  input  logic [2:0]             kind,
  input  logic [7:0]             byte_value,
  input  logic                   row,
  input  logic [5:0]             col,
  output lcdnw_pkg::state_t      st_next,
  output logic [TIMER_BITS-1:0]  cnt_next,
  output logic                   accepted
);
  import lcdnw_pkg::*;

  // Start one nibble: drive the data pins and raise the enable strobe.
  function automatic void start_nibble(input state_t si, input logic [3:0] nib,
                                       output state_t so, output logic [TIMER_BITS-1:0] co);
    so = si;
    so.data = nib;
    so.en = 1'b1;
    so.phase = PH_EN_HIGH;
    co = (cfg.pulse_high_us != 8'd0) ? TIMER_BITS'(cfg.pulse_high_us) : TIMER_BITS'(1);
  endfunction

  // Start a byte: latch it and send the high nibble.
  function automatic void start_byte(input state_t si, input logic rs, input logic [7:0] b,
                                     output state_t so, output logic [TIMER_BITS-1:0] co);
    state_t t;
    t = si;
    t.rs = rs;
    t.pending_byte = b;
    t.low_nibble_next = 1'b1;
    start_nibble(t, b[7:4], so, co);
  endfunction

  // Action taken when the wait of the current phase has run out.
  function automatic void finish(input state_t si, output state_t so,
                                 output logic [TIMER_BITS-1:0] co);
    state_t t;
    logic [7:0] w;
    t = si;
    w = CMD_CLEAR;
    so = si;
    co = '0;
    unique case (si.phase)
      PH_POWER: begin
        start_nibble(si, NIB_INIT3, so, co);
      end
      PH_EN_HIGH: begin
        so.en = 1'b0;
        so.phase = PH_SETTLE;
        co = (cfg.nibble_settle_us != 10'd0) ? TIMER_BITS'(cfg.nibble_settle_us)
                                             : TIMER_BITS'(1);
      end
      PH_SETTLE: begin
        if (si.init_step >= 4'd1 && si.init_step <= 4'd4) begin
          so.phase = PH_EXTRA;
          co = (si.init_step <= 4'd2) ? TIMER_BITS'(INIT_LONG_US) : TIMER_BITS'(INIT_SHORT_US);
        end else if (si.low_nibble_next) begin
          t.low_nibble_next = 1'b0;
          start_nibble(t, si.pending_byte[3:0], so, co);
        end else begin
          so.phase = PH_EXTRA;
          if (si.rs) begin
            co = TIMER_BITS'(cfg.data_hold_us);
          end else if (si.pending_byte == CMD_CLEAR || si.pending_byte == CMD_HOME) begin
            co = TIMER_BITS'(cfg.slow_command_us);
          end else begin
            co = '0;
          end
        end
      end
      PH_EXTRA: begin
        // Move on to the next nibble or byte of initialization, or finish.
        t.init_step = si.init_step + 4'd1;
        if (si.init_step >= 4'd1 && si.init_step <= 4'd3) begin
          start_nibble(t, (t.init_step == 4'd4) ? NIB_INIT2 : NIB_INIT3, so, co);
        end else if (si.init_step >= 4'd4 && si.init_step <= 4'd7) begin
          case (t.init_step)
            4'd5:    w = cfg.function_set_word;
            4'd6:    w = cfg.display_control_word;
            4'd7:    w = cfg.entry_mode_word;
            default: w = CMD_CLEAR;
          endcase
          start_byte(t, 1'b0, w, so, co);
        end else begin
          so.init_step = 4'd0;
          so.phase = PH_IDLE;
          co = '0;
        end
      end
      default: begin
        so.phase = PH_IDLE;
        so.en = 1'b0;
        co = '0;
      end
    endcase
  endfunction

  state_t s0, s1, s2;
  logic [TIMER_BITS-1:0] c0, c1, c2;
  logic [6:0] cursor_addr;
  logic busy;

  assign busy = (st.phase != PH_IDLE);
  assign cursor_addr = (row ? ROW1_BASE : 7'h00) + {1'b0, col};

  // Apply the beat itself: a tick counts down, a request starts a sequence.
  always_comb begin
    s0 = st;
    c0 = cnt;
    accepted = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        if (busy) c0 = cnt - TIMER_BITS'(1);
      end
      KIND_CMD: begin
        if (!busy) begin
          accepted = 1'b1;
          start_byte(st, 1'b0, byte_value, s0, c0);
        end
      end
      KIND_DATA: begin
        if (!busy) begin
          accepted = 1'b1;
          start_byte(st, 1'b1, byte_value, s0, c0);
        end
      end
      KIND_CURSOR: begin
        if (!busy) begin
          accepted = 1'b1;
          start_byte(st, 1'b0, CMD_SET_DDRAM | {1'b0, cursor_addr}, s0, c0);
        end
      end
      KIND_INIT: begin
        if (!busy) begin
          accepted = 1'b1;
          s0.rs = 1'b0;
          s0.en = 1'b0;
          s0.data = 4'h0;
          s0.low_nibble_next = 1'b0;
          s0.pending_byte = 8'h00;
          s0.init_step = 4'd1;
          s0.phase = PH_POWER;
          c0 = TIMER_BITS'(cfg.power_up_us);
        end
      end
      default: begin
      end
    endcase
  end

  // Expired waits: a zero wait can at most chain into one more phase change,
  // since enable and settle waits are never shorter than one tick.
  always_comb begin
    s1 = s0;
    c1 = c0;
    if (s0.phase != PH_IDLE && c0 == '0) finish(s0, s1, c1);
  end

  always_comb begin
    s2 = s1;
    c2 = c1;
    if (s1.phase != PH_IDLE && c1 == '0) finish(s1, s2, c2);
  end

  assign st_next = s2;
  assign cnt_next = c2;

endmodule
